// ===== design/rlp_pkg.sv =====
// rlp_pkg: shared constants, word types and cell control struct for the RLP stream decoder.
// No dependencies.
package rlp_pkg;

    localparam int MAX_DEPTH = 8;
    localparam int LEN_BITS  = 32;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int LBL_W     = 4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NONCANON   = 3'd1;
    localparam logic [2:0] ERR_LEAD_ZERO  = 3'd2;
    localparam logic [2:0] ERR_SHORT_LIST = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd4;
    localparam logic [2:0] ERR_OVERRUN    = 3'd5;
    localparam logic [2:0] ERR_DEPTH      = 3'd6;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } rlp_in_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       item_start;
        logic       item_end;
        logic       empty_item;
        logic       top_item_done;
        logic [2:0] error_code;
    } rlp_out_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic step;    // a byte is consumed this cycle and no error is latched
        logic active;  // this cell holds an open list
        logic top;     // this cell is the innermost open list
        logic load;    // open a new list in this cell
    } rlp_cell_ctl_t;

endpackage

// ===== design/rlp_list_cell.sv =====
// rlp_list_cell: one level of the open-list stack; holds the remaining byte count.
// Depends on rlp_pkg.
module rlp_list_cell
    import rlp_pkg::*;
(
    input  logic                aclk,
    input  rlp_cell_ctl_t       ctl,
    input  logic [LEN_BITS-1:0] load_len,
    input  logic                keep_in,
    input  logic [LEN_BITS-1:0] room_in,
    output logic                keep_out,
    output logic [LEN_BITS-1:0] room_out
);

    logic [LEN_BITS-1:0] rem_reg;
    logic [LEN_BITS-1:0] rem_dec;

    assign rem_dec  = rem_reg - LEN_BITS'(1);
    // still open after this byte, and every outer level too
    assign keep_out = keep_in & ctl.active & (rem_dec != '0);
    assign room_out = ctl.top ? rem_dec : room_in;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg <= load_len;
        end else if (ctl.step && ctl.active) begin
            rem_reg <= rem_dec;
        end
    end

endmodule

// ===== design/rlp_stream_decoder_top.sv =====
// rlp_stream_decoder_top: streaming RLP decoder, one word (byte) per cycle while s_ready is high.
// Depends on rlp_pkg and rlp_list_cell.
// A result word is registered and appears on m_ in the cycle after its input word is accepted.
// Throughput: one input word per cycle while s_ready is high; the decode and the list-stack
// update are combinational, every open level decrementing in its own cell in parallel.
// Reset: aresetn synchronous active low clears the parser and the output valid;
// the parser also returns to idle after each word marked end_of_data.
module rlp_stream_decoder_top
    import rlp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rlp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rlp_out_t m_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_FIRST,
        PH_MORE,
        PH_SHORT1
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [LEN_BITS-1:0] item_rem_reg, item_rem_next;
    logic [LBL_W-1:0]    lbl_reg, lbl_next;
    logic [LEN_BITS-1:0] acc_reg, acc_next;
    logic                is_list_reg, is_list_next;
    logic                err_lat_reg, err_lat_next;
    logic                m_valid_reg, m_valid_next;
    rlp_out_t            m_data_reg, m_data_next;

    // output register decouples the two sides
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    logic accept;
    assign accept = s_valid && s_ready;

    // stack of open lists as a chain of cells
    logic                step;
    logic                push;
    logic [LEN_BITS-1:0] push_len;
    logic [MAX_DEPTH:0]  keep_chain;
    logic [LEN_BITS-1:0] room_chain [MAX_DEPTH+1];
    logic [LEN_BITS-1:0] room;
    logic [DEPTH_W-1:0]  pop_depth;

    assign keep_chain[0] = 1'b1;
    assign room_chain[0] = '0;
    assign room          = room_chain[MAX_DEPTH];

    genvar g;
    generate
        for (g = 0; g < MAX_DEPTH; g++) begin : g_cell
            rlp_cell_ctl_t ctl;
            assign ctl.step   = step;
            assign ctl.active = depth_reg > DEPTH_W'(g);
            assign ctl.top    = depth_reg == DEPTH_W'(g + 1);
            assign ctl.load   = push && (depth_reg == DEPTH_W'(g));
            rlp_list_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .load_len (push_len),
                .keep_in  (keep_chain[g]),
                .room_in  (room_chain[g]),
                .keep_out (keep_chain[g+1]),
                .room_out (room_chain[g+1])
            );
        end
    endgenerate

    // keep bits form a thermometer: their count is the depth after popping
    always_comb begin
        logic [DEPTH_W-1:0] cnt;
        cnt = '0;
        for (int i = 1; i <= MAX_DEPTH; i++) begin
            cnt = cnt + DEPTH_W'(keep_chain[i]);
        end
        pop_depth = cnt;
    end

    logic [7:0]          b;
    logic                eod;
    logic [2:0]          err;
    logic                done;
    logic                at_top;
    logic [7:0]          b_sub;
    logic [LEN_BITS-1:0] short_len;
    logic [LEN_BITS-1:0] nbytes;
    logic [LEN_BITS+7:0] acc_wide;
    logic [LEN_BITS-1:0] acc_shift;
    logic [LBL_W-1:0]    lbl_dec;
    logic [LEN_BITS-1:0] item_dec;
    rlp_out_t            res;

    assign b         = s_data.data_byte;
    assign eod       = s_data.end_of_data;
    assign at_top    = depth_reg == '0;
    assign b_sub     = b - 8'h80;
    assign short_len = LEN_BITS'(b_sub);
    assign acc_wide  = {acc_reg, b};
    assign acc_shift = acc_wide[LEN_BITS-1:0];
    assign lbl_dec   = lbl_reg - LBL_W'(1);
    assign item_dec  = item_rem_reg - LEN_BITS'(1);

    always_comb begin
        phase_next    = phase_reg;
        depth_next    = depth_reg;
        item_rem_next = item_rem_reg;
        lbl_next      = lbl_reg;
        acc_next      = acc_reg;
        is_list_next  = is_list_reg;
        err_lat_next  = err_lat_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        res           = '0;
        err           = ERR_NONE;
        done          = 1'b0;
        push          = 1'b0;
        push_len      = '0;
        nbytes        = '0;
        step          = accept && !err_lat_reg;

        if (accept && m_ready) begin
            m_valid_next = 1'b0;
        end else if (!accept && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept && !err_lat_reg) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (b <= 8'h7f) begin
                        res.payload_byte = b;
                        res.byte_valid   = 1'b1;
                        res.item_start   = 1'b1;
                        res.item_end     = 1'b1;
                        done             = 1'b1;
                    end else if (b == 8'h80) begin
                        res.item_end   = 1'b1;
                        res.empty_item = 1'b1;
                        done           = 1'b1;
                    end else if (b <= 8'hb7) begin
                        if (!at_top && short_len > room) begin
                            err = ERR_OVERRUN;
                        end else begin
                            item_rem_next = short_len;
                            phase_next    = (short_len == LEN_BITS'(1)) ? PH_SHORT1 : PH_FIRST;
                        end
                    end else if (b <= 8'hbf || b >= 8'hf8) begin
                        // long-form length prefix, string or list
                        nbytes = LEN_BITS'((b <= 8'hbf) ? LBL_W'(b - 8'hb7)
                                                        : LBL_W'(b - 8'hf7));
                        if (!at_top && nbytes > room) begin
                            err = ERR_OVERRUN;
                        end else begin
                            lbl_next     = LBL_W'(nbytes);
                            acc_next     = '0;
                            is_list_next = b >= 8'hf8;
                            phase_next   = PH_LEN;
                        end
                    end else if (b == 8'hc0) begin
                        done = 1'b1;
                    end else begin
                        push_len = LEN_BITS'(8'(b - 8'hc0));
                        if (!at_top && push_len > room) begin
                            err = ERR_OVERRUN;
                        end else if (depth_reg == DEPTH_W'(MAX_DEPTH)) begin
                            err = ERR_DEPTH;
                        end else begin
                            push       = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_LEN: begin
                    if (acc_reg == '0 && b == 8'h00 && lbl_reg >= LBL_W'(2)) begin
                        err = ERR_LEAD_ZERO;
                    end else if ((acc_reg >> (LEN_BITS - 8)) != '0) begin
                        err = ERR_TOO_LONG;
                    end else begin
                        acc_next = acc_shift;
                        lbl_next = lbl_dec;
                        if (lbl_dec == '0) begin
                            acc_next = '0;
                            if (is_list_reg) begin
                                push_len = acc_shift;
                                if (acc_shift < LEN_BITS'(56)) begin
                                    err = ERR_SHORT_LIST;
                                end else if (!at_top && acc_shift > room) begin
                                    err = ERR_OVERRUN;
                                end else if (depth_reg == DEPTH_W'(MAX_DEPTH)) begin
                                    err = ERR_DEPTH;
                                end else begin
                                    push       = 1'b1;
                                    depth_next = depth_reg + DEPTH_W'(1);
                                    phase_next = PH_IDLE;
                                end
                            end else if (!at_top && acc_shift > room) begin
                                err = ERR_OVERRUN;
                            end else if (acc_shift == '0) begin
                                res.item_end   = 1'b1;
                                res.empty_item = 1'b1;
                                done           = 1'b1;
                            end else begin
                                item_rem_next = acc_shift;
                                phase_next    = PH_FIRST;
                            end
                        end
                    end
                end
                default: begin
                    if (phase_reg == PH_SHORT1 && b <= 8'h7f) begin
                        err = ERR_NONCANON;
                    end else begin
                        res.payload_byte = b;
                        res.byte_valid   = 1'b1;
                        res.item_start   = phase_reg != PH_MORE;
                        item_rem_next    = item_dec;
                        if (item_dec == '0) begin
                            res.item_end = 1'b1;
                            done         = 1'b1;
                        end else begin
                            phase_next = PH_MORE;
                        end
                    end
                end
            endcase

            if (err == ERR_NONE && done) begin
                phase_next        = PH_IDLE;
                depth_next        = pop_depth;
                res.top_item_done = pop_depth == '0;
            end
            if (err == ERR_NONE && eod && (phase_next != PH_IDLE || depth_next != '0)) begin
                err = ERR_TRUNCATED;
            end
            if (err != ERR_NONE) begin
                res            = '0;
                res.error_code = err;
                err_lat_next   = 1'b1;
                push           = 1'b0;
            end
            m_valid_next = (err != ERR_NONE) || res.byte_valid || res.empty_item
                           || res.top_item_done;
            m_data_next  = res;
        end

        if (accept && eod) begin
            phase_next    = PH_IDLE;
            depth_next    = '0;
            item_rem_next = '0;
            lbl_next      = '0;
            acc_next      = '0;
            is_list_next  = 1'b0;
            err_lat_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            depth_reg    <= '0;
            item_rem_reg <= '0;
            lbl_reg      <= '0;
            acc_reg      <= '0;
            is_list_reg  <= 1'b0;
            err_lat_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            depth_reg    <= depth_next;
            item_rem_reg <= item_rem_next;
            lbl_reg      <= lbl_next;
            acc_reg      <= acc_next;
            is_list_reg  <= is_list_next;
            err_lat_reg  <= err_lat_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule
